FILE: rtl/precharge_contactor_sequencer_core_macros.svh
// assertion macros shared by the sequencer checker
`ifndef PRECHARGE_CONTACTOR_SEQUENCER_CORE_MACROS_SVH
`define PRECHARGE_CONTACTOR_SEQUENCER_CORE_MACROS_SVH

// consequent must hold in the same cycle as the antecedent
`define PCS_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent must hold in the cycle after the antecedent
`define PCS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/pcs_pkg.sv
// shared constants of the precharge contactor sequencer
package pcs_pkg;

    // field widths
    localparam int REQ_W     = 2;
    localparam int MV_W      = 13;
    localparam int TEMP_W    = 8;
    localparam int MSUM_W    = 18;
    localparam int TIME_W    = 32;
    localparam int CPU_W     = 2;
    localparam int BUS_W     = 10;
    localparam int CANID_W   = 29;
    localparam int STATE_W   = 3;
    localparam int REPORT_W  = 2;
    localparam int PERIOD_W  = 16;
    localparam int PCT_W     = 7;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 29;

    // pack sum kept as whole volts plus leftover millivolts
    localparam int VOLT_W    = 12;
    localparam int REM_W     = 10;
    localparam int QEST_W    = 9;
    localparam int RECIP_W   = 19;
    localparam int RECIP_SH  = 28;
    localparam int PROD_W    = MSUM_W + RECIP_W;
    localparam logic [RECIP_W-1:0] SUM_RECIP = 19'd268435;   // floor(2^28 / 1000)
    localparam logic [MSUM_W-1:0]  MV_PER_V  = 18'd1000;
    localparam logic [VOLT_W-1:0]  SAT_VOLTS = 12'd2097;     // 2^21 - 1 = 2097 V + 151 mV
    localparam logic [REM_W-1:0]   SAT_REM   = 10'd151;
    localparam logic [6:0]         BUS_SCALE = 7'd100;

    // request codes
    localparam logic [REQ_W-1:0] REQ_REPORT = 2'd0;
    localparam logic [REQ_W-1:0] REQ_TICK   = 2'd1;
    localparam logic [REQ_W-1:0] REQ_CAN    = 2'd2;

    // vehicle link status codes
    localparam logic [CPU_W-1:0] CPU_OK      = 2'd0;
    localparam logic [CPU_W-1:0] CPU_LINK_LOST = 2'd1;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_TELEM_PERIOD = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PRECHG_PCT   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_START    = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_CHARGER_ID   = 2'd3;

    // configuration reset values
    localparam logic [PERIOD_W-1:0] RST_TELEM_PERIOD = 16'd500;
    localparam logic [PCT_W-1:0]    RST_PRECHG_PCT   = 7'd90;
    localparam logic [MV_W-1:0]     RST_MIN_START    = 13'd4200;
    localparam logic [CANID_W-1:0]  RST_CHARGER_ID   = 29'd419385575;

    // sequencer state codes
    localparam logic [STATE_W-1:0] ST_START      = 3'd0;
    localparam logic [STATE_W-1:0] ST_PRECHARGE  = 3'd1;
    localparam logic [STATE_W-1:0] ST_TRANSITION = 3'd2;
    localparam logic [STATE_W-1:0] ST_RUN        = 3'd3;
    localparam logic [STATE_W-1:0] ST_ERROR      = 3'd4;

    // vehicle report codes
    localparam logic [REPORT_W-1:0] RPT_DISCONNECTED = 2'd0;
    localparam logic [REPORT_W-1:0] RPT_PRECHARGE    = 2'd1;
    localparam logic [REPORT_W-1:0] RPT_POWER        = 2'd2;
    localparam logic [REPORT_W-1:0] RPT_ERROR        = 2'd3;

endpackage

FILE: rtl/precharge_contactor_sequencer_core.sv
// battery pack precharge contactor sequencer, top level
//
// One word is accepted per cycle on the input channel. Module reports update the round
// minimum cell voltage, maximum temperature and saturating pack sum; a CAN word whose id
// matches the charger id latches the charger flag; a control tick steps the sequencer
// (start, precharge, transition, run, error) and produces one result word, the other
// request types produce none. A word is captured in the input register (where the module
// sum is estimated in whole volts by a reciprocal multiply) and is applied to the state
// when it leaves that register, where a tick result is loaded into the output register
// that drives out_valid. Throughput is one word per cycle; while a result waits for
// out_ready, a following tick is held in the input register and in_ready stays low
// until the result is taken.
// Configuration writes take effect at once, except min_voltage_start, which seeds the
// next round.
module precharge_contactor_sequencer_core (
    input  logic                              clk,
    input  logic                              rst_n,
    // configuration
    input  logic                              cfg_we,
    input  logic [pcs_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [pcs_pkg::CFG_DAT_W-1:0]     cfg_data,
    // input channel
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [pcs_pkg::REQ_W-1:0]         req_type,
    input  logic [pcs_pkg::MV_W-1:0]          module_min_v,
    input  logic [pcs_pkg::TEMP_W-1:0]        module_max_t,
    input  logic [pcs_pkg::MSUM_W-1:0]        module_sum_mv,
    input  logic [pcs_pkg::TIME_W-1:0]        time_ms,
    input  logic [pcs_pkg::CPU_W-1:0]         cpu_status,
    input  logic                              sdc_closed,
    input  logic [pcs_pkg::BUS_W-1:0]         dc_bus_v,
    input  logic [pcs_pkg::CANID_W-1:0]       can_id,
    // output channel
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [pcs_pkg::STATE_W-1:0]       fsm_state,
    output logic                              relay_air_neg,
    output logic                              relay_air_pos,
    output logic                              relay_precharge,
    output logic                              ams_ok,
    output logic [pcs_pkg::REPORT_W-1:0]      vehicle_report,
    output logic                              telemetry_send,
    output logic [pcs_pkg::MV_W-1:0]          telemetry_min_v,
    output logic [pcs_pkg::MV_W-1:0]          balance_target_v,
    output logic [pcs_pkg::TEMP_W-1:0]        pack_max_t
);
    import pcs_pkg::*;

    typedef enum logic [STATE_W-1:0] {
        S_START      = ST_START,
        S_PRECHARGE  = ST_PRECHARGE,
        S_TRANSITION = ST_TRANSITION,
        S_RUN        = ST_RUN,
        S_ERROR      = ST_ERROR
    } seq_t;

    // input stage registers
    logic                 in_valid_reg, in_valid_next;
    logic [REQ_W-1:0]     req_reg;
    logic [MV_W-1:0]      mod_min_reg;
    logic [TEMP_W-1:0]    mod_max_reg;
    logic [MSUM_W-1:0]    mod_sum_reg;
    logic [QEST_W-1:0]    qest_reg;
    logic [TIME_W-1:0]    time_reg;
    logic [CPU_W-1:0]     cpu_reg;
    logic                 sdc_reg;
    logic [BUS_W-1:0]     bus_reg;
    logic [CANID_W-1:0]   canid_reg;

    // configuration registers
    logic [PERIOD_W-1:0]  period_reg, period_next;
    logic [PCT_W-1:0]     pct_reg, pct_next;
    logic [MV_W-1:0]      min_start_reg, min_start_next;
    logic [CANID_W-1:0]   charger_id_reg, charger_id_next;

    // sequencer and round state
    seq_t                 state_reg, state_next;
    logic                 charger_reg, charger_next;
    logic [TIME_W-1:0]    last_tx_reg, last_tx_next;
    logic [MV_W-1:0]      rmin_reg, rmin_next;
    logic [TEMP_W-1:0]    rmax_reg, rmax_next;
    logic [VOLT_W-1:0]    volts_reg, volts_next;
    logic [REM_W-1:0]     rem_reg, rem_next;

    // output registers
    logic                 out_valid_reg, out_valid_next;
    logic [STATE_W-1:0]   o_state_reg, o_state_next;
    logic                 o_neg_reg, o_neg_next;
    logic                 o_pos_reg, o_pos_next;
    logic                 o_pre_reg, o_pre_next;
    logic [REPORT_W-1:0]  o_report_reg, o_report_next;
    logic                 o_send_reg, o_send_next;
    logic [MV_W-1:0]      o_min_reg, o_min_next;
    logic [TEMP_W-1:0]    o_max_reg, o_max_next;

    // handshake and datapath signals
    logic                 is_tick, out_free, b_fire, in_take;
    logic [PROD_W-1:0]    recip_prod;
    logic [MSUM_W-1:0]    qest_mv;
    logic [MSUM_W-1:0]    rs_full;
    logic [REM_W:0]       rs;
    logic [VOLT_W-1:0]    rem_sum;
    logic [QEST_W:0]      q_add;
    logic [REM_W-1:0]     rem_fix;
    logic [VOLT_W:0]      volts_sum;
    logic [VOLT_W+PCT_W-1:0] pack_pct;
    logic [BUS_W+6:0]     bus_pct;
    logic                 go_run;
    logic [TIME_W-1:0]    elapsed;
    logic                 tx_due;

    // flow control
    assign is_tick  = (req_reg == REQ_TICK);
    assign out_free = !out_valid_reg || out_ready;
    assign b_fire   = in_valid_reg && (!is_tick || out_free);
    assign in_ready = !in_valid_reg || b_fire;
    assign in_take  = in_valid && in_ready;

    // whole-volt estimate of the module sum, may be one low
    assign recip_prod = PROD_W'(module_sum_mv) * PROD_W'(SUM_RECIP);

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            req_reg     <= req_type;
            mod_min_reg <= module_min_v;
            mod_max_reg <= module_max_t;
            mod_sum_reg <= module_sum_mv;
            qest_reg    <= recip_prod[RECIP_SH +: QEST_W];
            time_reg    <= time_ms;
            cpu_reg     <= cpu_status;
            sdc_reg     <= sdc_closed;
            bus_reg     <= dc_bus_v;
            canid_reg   <= can_id;
        end
    end

    // correct the estimate and add into volts and leftover millivolts
    assign qest_mv  = MSUM_W'(qest_reg) * MV_PER_V;
    assign rs_full  = mod_sum_reg - qest_mv;
    assign rs       = rs_full[REM_W:0];
    assign rem_sum  = VOLT_W'(rem_reg) + VOLT_W'(rs);

    always_comb
    begin
        if (rem_sum >= VOLT_W'(2) * VOLT_W'(MV_PER_V))
        begin
            q_add   = (QEST_W+1)'(qest_reg) + (QEST_W+1)'(2);
            rem_fix = REM_W'(rem_sum - VOLT_W'(2) * VOLT_W'(MV_PER_V));
        end
        else if (rem_sum >= VOLT_W'(MV_PER_V))
        begin
            q_add   = (QEST_W+1)'(qest_reg) + (QEST_W+1)'(1);
            rem_fix = REM_W'(rem_sum - VOLT_W'(MV_PER_V));
        end
        else
        begin
            q_add   = (QEST_W+1)'(qest_reg);
            rem_fix = REM_W'(rem_sum);
        end
    end

    assign volts_sum = (VOLT_W+1)'(volts_reg) + (VOLT_W+1)'(q_add);

    // precharge end test: pack volts times percent against bus volts times 100
    assign pack_pct = (VOLT_W+PCT_W)'(volts_reg) * (VOLT_W+PCT_W)'(pct_reg);
    assign bus_pct  = (BUS_W+7)'(bus_reg) * (BUS_W+7)'(BUS_SCALE);
    assign go_run   = pack_pct < (VOLT_W+PCT_W)'(bus_pct);

    // telemetry timer
    assign elapsed = time_reg - last_tx_reg;
    assign tx_due  = elapsed > TIME_W'(period_reg);

    // next state of config, sequencer, round and result
    always_comb
    begin
        period_next     = period_reg;
        pct_next        = pct_reg;
        min_start_next  = min_start_reg;
        charger_id_next = charger_id_reg;
        state_next      = state_reg;
        charger_next    = charger_reg;
        last_tx_next    = last_tx_reg;
        rmin_next       = rmin_reg;
        rmax_next       = rmax_reg;
        volts_next      = volts_reg;
        rem_next        = rem_reg;
        o_state_next    = o_state_reg;
        o_neg_next      = o_neg_reg;
        o_pos_next      = o_pos_reg;
        o_pre_next      = o_pre_reg;
        o_report_next   = o_report_reg;
        o_send_next     = o_send_reg;
        o_min_next      = o_min_reg;
        o_max_next      = o_max_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        in_valid_next   = in_take || (in_valid_reg && !b_fire);

        // configuration write
        if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_TELEM_PERIOD: period_next     = cfg_data[PERIOD_W-1:0];
                CFG_PRECHG_PCT:   pct_next        = cfg_data[PCT_W-1:0];
                CFG_MIN_START:    min_start_next  = cfg_data[MV_W-1:0];
                CFG_CHARGER_ID:   charger_id_next = cfg_data[CANID_W-1:0];
                default:          ;
            endcase
        end

        if (b_fire)
        begin
            unique case (req_reg)
                // module report
                REQ_REPORT:
                begin
                    if (mod_min_reg < rmin_reg)
                        rmin_next = mod_min_reg;
                    if (mod_max_reg > rmax_reg)
                        rmax_next = mod_max_reg;
                    if (volts_sum > (VOLT_W+1)'(SAT_VOLTS) ||
                        (volts_sum == (VOLT_W+1)'(SAT_VOLTS) && rem_fix > SAT_REM))
                    begin
                        volts_next = SAT_VOLTS;
                        rem_next   = SAT_REM;
                    end
                    else
                    begin
                        volts_next = volts_sum[VOLT_W-1:0];
                        rem_next   = rem_fix;
                    end
                end
                // charger detection
                REQ_CAN:
                begin
                    if (canid_reg == charger_id_reg)
                        charger_next = 1'b1;
                end
                // control tick
                REQ_TICK:
                begin
                    o_send_next = 1'b0;
                    if (tx_due)
                    begin
                        o_send_next  = !charger_reg;
                        last_tx_next = time_reg;
                    end
                    o_neg_next    = 1'b0;
                    o_pos_next    = 1'b0;
                    o_pre_next    = 1'b0;
                    o_report_next = RPT_ERROR;
                    unique case (state_reg)
                        S_START:
                        begin
                            o_report_next = RPT_DISCONNECTED;
                            if (cpu_reg != CPU_LINK_LOST)
                                state_next = S_PRECHARGE;
                        end
                        S_PRECHARGE:
                        begin
                            o_neg_next    = 1'b1;
                            o_pre_next    = 1'b1;
                            o_report_next = RPT_PRECHARGE;
                            if (cpu_reg == CPU_OK)
                                state_next = S_TRANSITION;
                            else if (cpu_reg == CPU_LINK_LOST)
                                state_next = S_ERROR;
                        end
                        S_TRANSITION:
                        begin
                            o_neg_next    = 1'b1;
                            o_pre_next    = 1'b1;
                            o_report_next = RPT_PRECHARGE;
                            if (go_run)
                                state_next = S_RUN;
                        end
                        S_RUN:
                        begin
                            o_neg_next    = 1'b1;
                            o_pos_next    = 1'b1;
                            o_pre_next    = 1'b1;
                            o_report_next = RPT_POWER;
                            if ((cpu_reg == CPU_LINK_LOST && charger_reg) || !sdc_reg)
                                state_next = S_ERROR;
                        end
                        default:
                        begin
                            state_next = S_ERROR;
                        end
                    endcase
                    o_state_next   = state_next;
                    o_min_next     = rmin_reg;
                    o_max_next     = rmax_reg;
                    out_valid_next = 1'b1;
                    // new round
                    rmin_next  = min_start_reg;
                    rmax_next  = '0;
                    volts_next = '0;
                    rem_next   = '0;
                end
                default: ;
            endcase
        end
    end

    // state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg   <= 1'b0;
            period_reg     <= RST_TELEM_PERIOD;
            pct_reg        <= RST_PRECHG_PCT;
            min_start_reg  <= RST_MIN_START;
            charger_id_reg <= RST_CHARGER_ID;
            state_reg      <= S_START;
            charger_reg    <= 1'b0;
            last_tx_reg    <= '0;
            rmin_reg       <= RST_MIN_START;
            rmax_reg       <= '0;
            volts_reg      <= '0;
            rem_reg        <= '0;
            out_valid_reg  <= 1'b0;
            o_state_reg    <= ST_START;
            o_neg_reg      <= 1'b0;
            o_pos_reg      <= 1'b0;
            o_pre_reg      <= 1'b0;
            o_report_reg   <= RPT_DISCONNECTED;
            o_send_reg     <= 1'b0;
            o_min_reg      <= '0;
            o_max_reg      <= '0;
        end
        else
        begin
            in_valid_reg   <= in_valid_next;
            period_reg     <= period_next;
            pct_reg        <= pct_next;
            min_start_reg  <= min_start_next;
            charger_id_reg <= charger_id_next;
            state_reg      <= state_next;
            charger_reg    <= charger_next;
            last_tx_reg    <= last_tx_next;
            rmin_reg       <= rmin_next;
            rmax_reg       <= rmax_next;
            volts_reg      <= volts_next;
            rem_reg        <= rem_next;
            out_valid_reg  <= out_valid_next;
            o_state_reg    <= o_state_next;
            o_neg_reg      <= o_neg_next;
            o_pos_reg      <= o_pos_next;
            o_pre_reg      <= o_pre_next;
            o_report_reg   <= o_report_next;
            o_send_reg     <= o_send_next;
            o_min_reg      <= o_min_next;
            o_max_reg      <= o_max_next;
        end
    end

    // result word
    assign out_valid        = out_valid_reg;
    assign fsm_state        = o_state_reg;
    assign relay_air_neg    = o_neg_reg;
    assign relay_air_pos    = o_pos_reg;
    assign relay_precharge  = o_pre_reg;
    assign ams_ok           = o_neg_reg;
    assign vehicle_report   = o_report_reg;
    assign telemetry_send   = o_send_reg;
    assign telemetry_min_v  = o_min_reg;
    assign balance_target_v = o_min_reg;
    assign pack_max_t       = o_max_reg;

endmodule

FILE: rtl/pcs_checker.sv
// port-level checker for the sequencer, bound to the top level
`include "precharge_contactor_sequencer_core_macros.svh"

module pcs_checker (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              out_valid,
    input  logic                              out_ready,
    input  logic [pcs_pkg::STATE_W-1:0]       fsm_state,
    input  logic                              relay_air_neg,
    input  logic                              relay_air_pos,
    input  logic                              relay_precharge,
    input  logic                              ams_ok,
    input  logic [pcs_pkg::REPORT_W-1:0]      vehicle_report,
    input  logic [pcs_pkg::MV_W-1:0]          telemetry_min_v
);
    import pcs_pkg::*;

    // stalled result word holds its valid, state and minimum voltage
    `PCS_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(fsm_state) && $stable(telemetry_min_v), "result word changed while stalled")

    // system ok line follows the negative contactor
    `PCS_ASSERT_SAME(a_ams_ok, out_valid, ams_ok == relay_air_neg, "ams_ok differs from negative contactor")

    // positive contactor only closes with negative and precharge relays closed
    `PCS_ASSERT_SAME(a_pos_guard, out_valid && relay_air_pos, relay_air_neg && relay_precharge && vehicle_report == RPT_POWER, "positive contactor closed outside run")

    // a tick run in error stays in error with relays open
    `PCS_ASSERT_SAME(a_err_open, out_valid && vehicle_report == RPT_ERROR, fsm_state == ST_ERROR && !relay_air_neg && !relay_precharge, "error report without open relays")

    // error is sticky across consecutive results
    `PCS_ASSERT_NEXT(a_err_sticky, out_valid && out_ready && fsm_state == ST_ERROR, !out_valid || fsm_state == ST_ERROR, "left error state")

endmodule

bind precharge_contactor_sequencer_core pcs_checker u_pcs_checker (.*);
